// File: sv/ppfc_pkg.sv
package ppfc_pkg;

    localparam int NumAxes = 3;

    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_LOAD_PV = 2'd1,
        MODE_LOAD_ACC = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_GAIN_P = 3'd0,
        CFG_GAIN_I = 3'd1,
        CFG_GAIN_D = 3'd2,
        CFG_INT_LIM = 3'd3,
        CFG_MASS = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_INTEG,
        ST_ACC,
        ST_MAT,
        ST_ROT,
        ST_MASS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic do_err;
        logic do_integ;
        logic do_acc;
        logic do_rot;
        logic do_mass;
    } lane_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

    function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
        if (v > 16'sd16384) begin
            return 16'sd16384;
        end else if (v < -16'sd16384) begin
            return -16'sd16384;
        end
        return v;
    endfunction

endpackage

// File: sv/pid_position_force_controller.sv
// Three-axis PID force controller, Q16.16. Load and clear words are taken in the idle
// state and give no result; a measure word runs through three parallel axis lanes (error,
// e*dt product, integrator add with rotation matrix, gain sum, rotation, mass, output)
// and gives one result word, so the input is ready again once that result is loaded into
// the output register. One measure word is in work at a time; the output register lets later
// words in while a result waits, and a measure word that reaches its output stage holds
// there until the output register is free.
module pid_position_force_controller (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // stamp, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, quat_w, x, y, z
    input  logic [287:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z
    output logic [95:0]  m_tdata,
    // clipped
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    import ppfc_pkg::*;

    state_t state_reg, state_next;
    logic [23:0] gp_reg, gi_reg, gd_reg, mass_reg;
    logic [30:0] lim_reg;
    logic [31:0] last_reg, dt_reg;
    logic signed [31:0] tp_reg [3], tv_reg [3], ta_reg [3];
    logic signed [31:0] pos_reg [3], vel_reg [3];
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] rm_reg [3][3];
    logic out_valid_reg;
    logic [95:0] out_data_reg;
    logic out_clip_reg;
    logic out_load;
    logic clear_pulse;
    lane_ctl_t ctl;
    logic signed [31:0] acc_w [3], force_w [3];
    logic clip_w [3];
    logic accept;
    logic signed [31:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign clear_pulse = accept && (mode_t'(s_tuser) == MODE_CLEAR);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && mode_t'(s_tuser) == MODE_MEASURE) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                ctl.do_err = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                ctl.do_integ = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MAT;
            end
            ST_MAT: begin
                ctl.do_acc = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                ctl.do_rot = 1'b1;
                state_next = ST_MASS;
            end
            ST_MASS: begin
                ctl.do_mass = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the integrator add needs its e*dt product registered first
    logic integ_second;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_second <= 1'b0;
        end else begin
            integ_second <= ctl.do_integ;
        end
    end
    lane_ctl_t lane_ctl;
    always_comb begin
        lane_ctl = ctl;
        lane_ctl.do_integ = integ_second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gp_reg <= 24'd65536;
            gi_reg <= 24'd65536;
            gd_reg <= 24'd65536;
            lim_reg <= 31'd65536;
            mass_reg <= 24'd65536;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P: gp_reg <= cfg_data[23:0];
                CFG_GAIN_I: gi_reg <= cfg_data[23:0];
                CFG_GAIN_D: gd_reg <= cfg_data[23:0];
                CFG_INT_LIM: lim_reg <= cfg_data;
                CFG_MASS: mass_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
            for (int i = 0; i < NumAxes; i++) begin
                tp_reg[i] <= '0;
                tv_reg[i] <= '0;
                ta_reg[i] <= '0;
            end
        end else if (accept) begin
            unique case (mode_t'(s_tuser))
                MODE_MEASURE: begin
                    dt_reg <= s_tdata[31:0] - last_reg;
                    last_reg <= s_tdata[31:0];
                    for (int i = 0; i < NumAxes; i++) begin
                        pos_reg[i] <= s_tdata[32 + 32*i +: 32];
                        vel_reg[i] <= s_tdata[128 + 32*i +: 32];
                    end
                    qw_reg <= clamp_q(s_tdata[239:224]);
                    qx_reg <= clamp_q(s_tdata[255:240]);
                    qy_reg <= clamp_q(s_tdata[271:256]);
                    qz_reg <= clamp_q(s_tdata[287:272]);
                end
                MODE_LOAD_PV: begin
                    for (int i = 0; i < NumAxes; i++) begin
                        tp_reg[i] <= s_tdata[32 + 32*i +: 32];
                        tv_reg[i] <= s_tdata[128 + 32*i +: 32];
                    end
                end
                MODE_LOAD_ACC: begin
                    for (int i = 0; i < NumAxes; i++) begin
                        ta_reg[i] <= s_tdata[32 + 32*i +: 32];
                    end
                end
                MODE_CLEAR: last_reg <= '0;
                default: ;
            endcase
        end
    end

    assign qxx = qx_reg * qx_reg;
    assign qyy = qy_reg * qy_reg;
    assign qzz = qz_reg * qz_reg;
    assign qxy = qx_reg * qy_reg;
    assign qxz = qx_reg * qz_reg;
    assign qyz = qy_reg * qz_reg;
    assign qwx = qw_reg * qx_reg;
    assign qwy = qw_reg * qy_reg;
    assign qwz = qw_reg * qz_reg;

    // rm_reg[i][j] holds R(q)[j][i], the transposed entry used by lane i
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC) begin
            rm_reg[0][0] <= 32'(33'sd268435456 - 33'((qyy + qzz) <<< 1));
            rm_reg[0][1] <= 32'((33'(qxy) + 33'(qwz)) <<< 1);
            rm_reg[0][2] <= 32'((33'(qxz) - 33'(qwy)) <<< 1);
            rm_reg[1][0] <= 32'((33'(qxy) - 33'(qwz)) <<< 1);
            rm_reg[1][1] <= 32'(33'sd268435456 - 33'((qxx + qzz) <<< 1));
            rm_reg[1][2] <= 32'((33'(qyz) + 33'(qwx)) <<< 1);
            rm_reg[2][0] <= 32'((33'(qxz) + 33'(qwy)) <<< 1);
            rm_reg[2][1] <= 32'((33'(qyz) - 33'(qwx)) <<< 1);
            rm_reg[2][2] <= 32'(33'sd268435456 - 33'((qxx + qyy) <<< 1));
        end
    end

    for (genvar g = 0; g < NumAxes; g++) begin : g_lane
        ppfc_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .ctl(lane_ctl), .clear(clear_pulse),
            .pos(pos_reg[g]), .vel(vel_reg[g]), .tgt_pos(tp_reg[g]),
            .tgt_vel(tv_reg[g]), .tgt_acc(ta_reg[g]), .dt(dt_reg),
            .gain_p(gp_reg), .gain_i(gi_reg), .gain_d(gd_reg), .lim(lim_reg),
            .mass(mass_reg), .rm0(rm_reg[g][0]), .rm1(rm_reg[g][1]),
            .rm2(rm_reg[g][2]), .acc0(acc_w[0]), .acc1(acc_w[1]), .acc2(acc_w[2]),
            .acc(acc_w[g]), .force_val(force_w[g]), .clip(clip_w[g])
        );
    end

    // merge of the three lanes into the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_data_reg <= {force_w[2], force_w[1], force_w[0]};
            out_clip_reg <= clip_w[0] | clip_w[1] | clip_w[2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_clip_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !accept) else $error("accept while busy");
    a_result_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> m_tvalid) else $error("result lost");
    a_mass_before_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> ($past(state_reg) == ST_MASS || $past(state_reg) == ST_OUT))
        else $error("bad sequence");
endmodule

// File: sv/ppfc_lane.sv
module ppfc_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ppfc_pkg::lane_ctl_t    ctl,
    input  logic                   clear,
    input  logic signed [31:0]     pos,
    input  logic signed [31:0]     vel,
    input  logic signed [31:0]     tgt_pos,
    input  logic signed [31:0]     tgt_vel,
    input  logic signed [31:0]     tgt_acc,
    input  logic [31:0]            dt,
    input  logic [23:0]            gain_p,
    input  logic [23:0]            gain_i,
    input  logic [23:0]            gain_d,
    input  logic [30:0]            lim,
    input  logic [23:0]            mass,
    input  logic signed [31:0]     rm0,
    input  logic signed [31:0]     rm1,
    input  logic signed [31:0]     rm2,
    input  logic signed [31:0]     acc0,
    input  logic signed [31:0]     acc1,
    input  logic signed [31:0]     acc2,
    output logic signed [31:0]     acc,
    output logic signed [31:0]     force_val,
    output logic                   clip
);
    import ppfc_pkg::*;

    logic signed [31:0] e_reg, ev_reg, integ_reg, acc_reg, force_reg;
    // rotated vector is not saturated and needs up to 36 bits
    logic signed [35:0] rot_reg;
    logic signed [64:0] edt_reg;
    logic clip_reg;
    logic signed [65:0] d_e, d_ev, sum_acc, sum_rot, prod_m, s_int;
    logic signed [64:0] edt_next;

    assign d_e = 66'(pos) - 66'(tgt_pos);
    assign d_ev = 66'(vel) - 66'(tgt_vel);
    assign edt_next = 65'(e_reg) * $signed({1'b0, dt});
    assign s_int = 66'(integ_reg) + 66'(edt_reg >>> 16);
    assign sum_acc = (66'(tgt_acc) <<< 16) - 66'(e_reg) * $signed({1'b0, gain_p})
        - 66'(integ_reg) * $signed({1'b0, gain_i}) - 66'(ev_reg) * $signed({1'b0, gain_d});
    assign sum_rot = 66'(rm0) * 66'(acc0) + 66'(rm1) * 66'(acc1) + 66'(rm2) * 66'(acc2);
    assign prod_m = 66'(rot_reg) * $signed({1'b0, mass});

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            integ_reg <= '0;
        end else if (ctl.do_integ) begin
            if (s_int > 66'($signed({1'b0, lim}))) begin
                integ_reg <= $signed({1'b0, lim});
            end else if (s_int < -66'($signed({1'b0, lim}))) begin
                integ_reg <= -$signed({1'b0, lim});
            end else begin
                integ_reg <= s_int[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        // e*dt product, registered the cycle before the integrator add
        edt_reg <= edt_next;
        if (ctl.do_err) begin
            e_reg <= sat32(d_e);
            ev_reg <= sat32(d_ev);
            clip_reg <= ovf32(d_e) | ovf32(d_ev);
        end
        if (ctl.do_acc) begin
            acc_reg <= sat32(sum_acc >>> 16);
            clip_reg <= clip_reg | ovf32(sum_acc >>> 16);
        end
        if (ctl.do_rot) begin
            rot_reg <= 36'(sum_rot >>> 28);
        end
        if (ctl.do_mass) begin
            force_reg <= sat32(prod_m >>> 16);
            clip_reg <= clip_reg | ovf32(prod_m >>> 16);
        end
    end

    assign acc = acc_reg;
    assign force_val = force_reg;
    assign clip = clip_reg;
endmodule

// File: verif/pid_position_force_controller_tb.sv
module pid_position_force_controller_tb;
    import ppfc_pkg::*;

    typedef struct {
        mode_t             mode;
        logic [31:0]       stamp;
        logic signed [31:0] va [3];
        logic signed [31:0] vb [3];
        logic signed [15:0] q [4];
    } ctl_word_t;

    typedef struct {
        logic [31:0] force_v [3];
        logic        clipped;
    } force_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;

    pid_position_force_controller u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [23:0] kp, ki, kd, mass;
    logic [30:0] ilim;
    logic signed [31:0] integ [3];
    logic signed [31:0] tpos [3];
    logic signed [31:0] tvel [3];
    logic signed [31:0] tacc [3];
    logic [31:0] prev_stamp;

    force_word_t expected_forces [$];
    int errors;
    int mismatches;
    int idle_cycles;
    bit long_hold;
    bit stall_en;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic signed [63:0] fshift(logic signed [63:0] v, int k);
        return v >>> k;
    endfunction

    function automatic logic signed [31:0] sat(logic signed [63:0] v, inout logic clip);
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] qclamp(logic signed [15:0] v);
        if (v > 16'sd16384) return 64'sd16384;
        if (v < -16'sd16384) return -64'sd16384;
        return 64'(v);
    endfunction

    function automatic bit compute_force(ctl_word_t w, output force_word_t r);
        logic signed [31:0] e [3];
        logic signed [31:0] ev [3];
        logic signed [31:0] acc [3];
        logic signed [63:0] s, sum, rot, lim, qw, qx, qy, qz;
        logic signed [63:0] rm [3][3];
        logic [31:0] dt;
        logic clip;
        clip = 1'b0;
        case (w.mode)
            MODE_LOAD_PV: begin
                for (int i = 0; i < 3; i++) begin
                    tpos[i] = w.va[i];
                    tvel[i] = w.vb[i];
                end
                return 0;
            end
            MODE_LOAD_ACC: begin
                for (int i = 0; i < 3; i++) tacc[i] = w.va[i];
                return 0;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < 3; i++) integ[i] = 0;
                prev_stamp = 0;
                return 0;
            end
            default: ;
        endcase
        dt = w.stamp - prev_stamp;
        prev_stamp = w.stamp;
        lim = 64'(ilim);
        for (int i = 0; i < 3; i++) begin
            e[i] = sat(64'(w.va[i]) - 64'(tpos[i]), clip);
            ev[i] = sat(64'(w.vb[i]) - 64'(tvel[i]), clip);
            s = 64'(integ[i]) + fshift(64'(e[i]) * $signed({32'd0, dt}), 16);
            if (s > lim) s = lim;
            if (s < -lim) s = -lim;
            integ[i] = s[31:0];
        end
        for (int i = 0; i < 3; i++) begin
            sum = 64'(tacc[i]) * 64'sd65536 - $signed({40'd0, kp}) * 64'(e[i])
                - $signed({40'd0, ki}) * 64'(integ[i]) - $signed({40'd0, kd}) * 64'(ev[i]);
            acc[i] = sat(fshift(sum, 16), clip);
        end
        qw = qclamp(w.q[0]);
        qx = qclamp(w.q[1]);
        qy = qclamp(w.q[2]);
        qz = qclamp(w.q[3]);
        rm[0][0] = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        rm[0][1] = 2 * (qx * qy - qw * qz);
        rm[0][2] = 2 * (qx * qz + qw * qy);
        rm[1][0] = 2 * (qx * qy + qw * qz);
        rm[1][1] = 64'sd268435456 - 2 * (qx * qx + qz * qz);
        rm[1][2] = 2 * (qy * qz - qw * qx);
        rm[2][0] = 2 * (qx * qz - qw * qy);
        rm[2][1] = 2 * (qy * qz + qw * qx);
        rm[2][2] = 64'sd268435456 - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++) begin
            sum = 0;
            for (int j = 0; j < 3; j++) sum += rm[j][i] * 64'(acc[j]);
            rot = fshift(sum, 28);
            r.force_v[i] = sat(fshift(rot * $signed({40'd0, mass}), 16), clip);
        end
        r.clipped = clip;
        return 1;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_P: kp = val[23:0];
            CFG_GAIN_I: ki = val[23:0];
            CFG_GAIN_D: kd = val[23:0];
            CFG_INT_LIM: ilim = val;
            CFG_MASS: mass = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (expected_forces.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // one word with a possible gap ahead of it; s_tvalid stays high across back-to-back words
    task automatic send_word(ctl_word_t w, int gap);
        force_word_t r;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.mode;
        s_tdata <= {w.q[3], w.q[2], w.q[1], w.q[0], w.vb[2], w.vb[1], w.vb[0],
                    w.va[2], w.va[1], w.va[0], w.stamp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (compute_force(w, r)) expected_forces.push_back(r);
    endtask

    task automatic send_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic ctl_word_t rand_word(mode_t m, bit wide);
        ctl_word_t w;
        w.mode = m;
        w.stamp = wide ? $urandom : $urandom_range(0, 200000);
        for (int i = 0; i < 3; i++) begin
            w.va[i] = wide ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
            w.vb[i] = wide ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
        end
        for (int i = 0; i < 4; i++)
            w.q[i] = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 32768)) - 16'sd16384;
        return w;
    endfunction

    // result checker
    always @(posedge aclk) begin
        force_word_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_forces.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word %h", m_tdata);
            end else begin
                exp_r = expected_forces.pop_front();
                if (m_tdata !== {exp_r.force_v[2], exp_r.force_v[1], exp_r.force_v[0]}
                    || m_tuser !== exp_r.clipped) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("force exp %h %h %h clip %b got %h clip %b",
                                 exp_r.force_v[0], exp_r.force_v[1], exp_r.force_v[2],
                                 exp_r.clipped, m_tdata, m_tuser);
                end
            end
        end
    end

    // receiver stall pattern plus one long hold
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold) begin
            m_tready <= 1'b0;
        end else if (stall_en) begin
            hold = $urandom_range(0, 7);
            m_tready <= (hold > 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("pid_position_force_controller: mismatch");
            $finish;
        end
    end

    initial begin
        ctl_word_t w;
        ctl_word_t dir_tab [$];
        force_word_t r;
        int burst;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_MEASURE;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN_P;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        stall_en = 1'b0;
        kp = 24'd65536; ki = 24'd65536; kd = 24'd65536; mass = 24'd65536;
        ilim = 31'd65536;
        prev_stamp = 0;
        for (int i = 0; i < 3; i++) begin
            integ[i] = 0; tpos[i] = 0; tvel[i] = 0; tacc[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: measure after reset with zero data and identity attitude gives zero force
        w = rand_word(MODE_MEASURE, 0);
        w.stamp = 32'h0001_0000;
        for (int i = 0; i < 3; i++) begin w.va[i] = 0; w.vb[i] = 0; end
        w.q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        begin
            ctl_word_t tmp;
            tmp = w;
            void'(compute_force(tmp, r));
            // undo the state change; the row is replayed by send_word
            prev_stamp = 0;
            if (r.force_v[0] != 0 || r.clipped) errors++;
        end
        dir_tab.push_back(w);
        // extremes of every field, all modes, out-of-range and non-unit quaternions
        w.mode = MODE_LOAD_PV;
        for (int i = 0; i < 3; i++) begin w.va[i] = 32'sh7fffffff; w.vb[i] = 32'sh80000000; end
        dir_tab.push_back(w);
        w.mode = MODE_MEASURE; w.stamp = 32'hffff_ffff;
        for (int i = 0; i < 3; i++) begin w.va[i] = 32'sh80000000; w.vb[i] = 32'sh7fffffff; end
        w.q = '{16'sh7fff, 16'sh8000, 16'sd16384, -16'sd16384};
        dir_tab.push_back(w);
        w.mode = MODE_LOAD_ACC;
        for (int i = 0; i < 3; i++) w.va[i] = 32'sh7fffffff;
        dir_tab.push_back(w);
        w.mode = MODE_MEASURE; w.stamp = 32'h0000_0010;
        w.q = '{16'sd100, 16'sd0, 16'sd0, 16'sd0};
        dir_tab.push_back(w);
        w.mode = MODE_CLEAR;
        dir_tab.push_back(w);
        w.mode = MODE_MEASURE; w.stamp = 32'h0000_ffff;
        w.q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        dir_tab.push_back(w);
        w.mode = MODE_LOAD_ACC;
        for (int i = 0; i < 3; i++) w.va[i] = 32'sh80000000;
        dir_tab.push_back(w);
        w.mode = MODE_MEASURE; w.stamp = 32'h0;
        for (int i = 0; i < 3; i++) begin w.va[i] = 0; w.vb[i] = 0; end
        w.q = '{-16'sd16384, 16'sd16384, 16'sh8000, 16'sh7fff};
        dir_tab.push_back(w);
        foreach (dir_tab[k]) send_word(dir_tab[k], 0);
        send_idle();
        drain();

        // random phases over register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_GAIN_P, 31'd0); write_reg(CFG_GAIN_I, 31'd0);
                    write_reg(CFG_GAIN_D, 31'd0); write_reg(CFG_INT_LIM, 31'd0);
                    write_reg(CFG_MASS, 31'd0);
                end
                1: begin
                    write_reg(CFG_GAIN_P, 31'hffffff); write_reg(CFG_GAIN_I, 31'hffffff);
                    write_reg(CFG_GAIN_D, 31'hffffff); write_reg(CFG_INT_LIM, 31'h7fffffff);
                    write_reg(CFG_MASS, 31'hffffff);
                end
                default: begin
                    write_reg(CFG_GAIN_P, 31'($urandom_range(0, 24'hffffff)));
                    write_reg(CFG_GAIN_I, 31'($urandom_range(0, 24'h3ffff)));
                    write_reg(CFG_GAIN_D, 31'($urandom_range(0, 24'hffffff)));
                    write_reg(CFG_INT_LIM, 31'($urandom));
                    write_reg(CFG_MASS, 31'($urandom_range(0, 24'h3ffff)));
                end
            endcase
            stall_en = (ph % 2 == 1);
            for (int n = 0; n < 65; n += burst) begin
                mode_t m;
                int pick;
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst; b++) begin
                    pick = $urandom_range(0, 9);
                    m = (pick < 6) ? MODE_MEASURE : (pick < 8) ? MODE_LOAD_PV
                      : (pick < 9) ? MODE_LOAD_ACC : MODE_CLEAR;
                    send_word(rand_word(m, $urandom_range(0, 3) == 0),
                              (b == 0) ? $urandom_range(0, 12) : 0);
                end
                if (ph == 2 && n == 0) begin
                    long_hold = 1'b1;
                    fork
                        begin
                            repeat (300) @(posedge aclk);
                            long_hold = 1'b0;
                        end
                    join_none
                end
                if (ph == 3 && n > 30 && n < 40) begin
                    send_idle();
                    while (expected_forces.size() != 0) @(posedge aclk);
                end
            end
            send_idle();
            drain();
        end

        if (errors == 0) begin
            $display("pid_position_force_controller: match");
        end else begin
            $display("pid_position_force_controller: mismatch");
        end
        $finish;
    end
endmodule

// File: pid_position_force_controller.f
sv/ppfc_pkg.sv
sv/ppfc_lane.sv
sv/pid_position_force_controller.sv
verif/pid_position_force_controller_tb.sv
